// ----- rtl/shg_pkg.sv -----
// shared types, constants and constant tables for the scrambled halton generator
// no dependencies
package shg_pkg;

  localparam int MaxDimensions = 360;
  localparam int DigitCount    = 32;
  localparam int FractionBits  = 40;
  localparam int TableDims     = 360;

  localparam int DimW   = 9;
  localparam int IndexW = 32;
  localparam int PosW   = 5;
  localparam int BaseW  = 12;
  localparam int CoordW = 32;

  localparam logic OP_GENERATE = 1'b0;
  localparam logic OP_LOAD     = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [DimW-1:0]   dimension;
    logic [IndexW-1:0] point_index;
    logic [PosW-1:0]   digit_position;
    logic [BaseW-1:0]  shift_digit;
  } in_req_t;

  typedef struct packed {
    logic [CoordW-1:0] coordinate;
    logic [DimW-1:0]   dimension_echo;
  } out_res_t;

  localparam logic [BaseW-1:0] BASE_TABLE [TableDims] = '{
    12'd2,12'd3,12'd5,12'd7,12'd11,12'd13,12'd17,12'd19,12'd23,12'd29,12'd31,12'd37,
    12'd41,12'd43,12'd47,12'd53,12'd59,12'd61,12'd67,12'd71,12'd73,12'd79,12'd83,12'd89,
    12'd97,12'd101,12'd103,12'd107,12'd109,12'd113,12'd127,12'd131,12'd137,12'd139,
    12'd149,12'd151,12'd157,12'd163,12'd167,12'd173,12'd179,12'd181,12'd191,12'd193,
    12'd197,12'd199,12'd211,12'd223,12'd227,12'd229,12'd233,12'd239,12'd241,12'd251,
    12'd257,12'd263,12'd269,12'd271,12'd277,12'd281,12'd283,12'd293,12'd307,12'd311,
    12'd313,12'd317,12'd331,12'd337,12'd347,12'd349,12'd353,12'd359,12'd367,12'd373,
    12'd379,12'd383,12'd389,12'd397,12'd401,12'd409,12'd419,12'd421,12'd431,12'd433,
    12'd439,12'd443,12'd449,12'd457,12'd461,12'd463,12'd467,12'd479,12'd487,12'd491,
    12'd499,12'd503,12'd509,12'd521,12'd523,12'd541,12'd547,12'd557,12'd563,12'd569,
    12'd571,12'd577,12'd587,12'd593,12'd599,12'd601,12'd607,12'd613,12'd617,12'd619,
    12'd631,12'd641,12'd643,12'd647,12'd653,12'd659,12'd661,12'd673,12'd677,12'd683,
    12'd691,12'd701,12'd709,12'd719,12'd727,12'd733,12'd739,12'd743,12'd751,12'd757,
    12'd761,12'd769,12'd773,12'd787,12'd797,12'd809,12'd811,12'd821,12'd823,12'd827,
    12'd829,12'd839,12'd853,12'd857,12'd859,12'd863,12'd877,12'd881,12'd883,12'd887,
    12'd907,12'd911,12'd919,12'd929,12'd937,12'd941,12'd947,12'd953,12'd967,12'd971,
    12'd977,12'd983,12'd991,12'd997,12'd1009,12'd1013,12'd1019,12'd1021,12'd1031,
    12'd1033,12'd1039,12'd1049,12'd1051,12'd1061,12'd1063,12'd1069,12'd1087,12'd1091,
    12'd1093,12'd1097,12'd1103,12'd1109,12'd1117,12'd1123,12'd1129,12'd1151,12'd1153,
    12'd1163,12'd1171,12'd1181,12'd1187,12'd1193,12'd1201,12'd1213,12'd1217,12'd1223,
    12'd1229,12'd1231,12'd1237,12'd1249,12'd1259,12'd1277,12'd1279,12'd1283,12'd1289,
    12'd1291,12'd1297,12'd1301,12'd1303,12'd1307,12'd1319,12'd1321,12'd1327,12'd1361,
    12'd1367,12'd1373,12'd1381,12'd1399,12'd1409,12'd1423,12'd1427,12'd1429,12'd1433,
    12'd1439,12'd1447,12'd1451,12'd1453,12'd1459,12'd1471,12'd1481,12'd1483,12'd1487,
    12'd1489,12'd1493,12'd1499,12'd1511,12'd1523,12'd1531,12'd1543,12'd1549,12'd1553,
    12'd1559,12'd1567,12'd1571,12'd1579,12'd1583,12'd1597,12'd1601,12'd1607,12'd1609,
    12'd1613,12'd1619,12'd1621,12'd1627,12'd1637,12'd1657,12'd1663,12'd1667,12'd1669,
    12'd1693,12'd1697,12'd1699,12'd1709,12'd1721,12'd1723,12'd1733,12'd1741,12'd1747,
    12'd1753,12'd1759,12'd1777,12'd1783,12'd1787,12'd1789,12'd1801,12'd1811,12'd1823,
    12'd1831,12'd1847,12'd1861,12'd1867,12'd1871,12'd1873,12'd1877,12'd1879,12'd1889,
    12'd1901,12'd1907,12'd1913,12'd1931,12'd1933,12'd1949,12'd1951,12'd1973,12'd1979,
    12'd1987,12'd1993,12'd1997,12'd1999,12'd2003,12'd2011,12'd2017,12'd2027,12'd2029,
    12'd2039,12'd2053,12'd2063,12'd2069,12'd2081,12'd2083,12'd2087,12'd2089,12'd2099,
    12'd2111,12'd2113,12'd2129,12'd2131,12'd2137,12'd2141,12'd2143,12'd2153,12'd2161,
    12'd2179,12'd2203,12'd2207,12'd2213,12'd2221,12'd2237,12'd2239,12'd2243,12'd2251,
    12'd2267,12'd2269,12'd2273,12'd2281,12'd2287,12'd2293,12'd2297,12'd2309,12'd2311,
    12'd2333,12'd2339,12'd2341,12'd2347,12'd2351,12'd2357,12'd2371,12'd2377,12'd2381,
    12'd2383,12'd2389,12'd2393,12'd2399,12'd2411,12'd2417,12'd2423
  };

  localparam logic [BaseW-1:0] FACTOR_TABLE [TableDims] = '{
    12'd1,12'd1,12'd3,12'd3,12'd4,12'd9,12'd7,12'd5,12'd9,12'd18,12'd18,12'd8,12'd13,
    12'd31,12'd9,12'd19,12'd36,12'd33,12'd21,12'd44,12'd43,12'd61,12'd60,12'd56,12'd26,
    12'd71,12'd32,12'd77,12'd26,12'd95,12'd92,12'd47,12'd29,12'd61,12'd57,12'd69,
    12'd115,12'd63,12'd92,12'd31,12'd104,12'd126,12'd50,12'd80,12'd55,12'd152,12'd114,
    12'd80,12'd83,12'd97,12'd95,12'd150,12'd148,12'd55,12'd80,12'd192,12'd71,12'd76,
    12'd82,12'd109,12'd105,12'd173,12'd58,12'd143,12'd56,12'd177,12'd203,12'd239,
    12'd196,12'd143,12'd278,12'd227,12'd87,12'd274,12'd264,12'd84,12'd226,12'd163,
    12'd231,12'd177,12'd95,12'd116,12'd165,12'd131,12'd156,12'd105,12'd188,12'd142,
    12'd105,12'd125,12'd269,12'd292,12'd215,12'd182,12'd294,12'd152,12'd148,12'd144,
    12'd382,12'd194,12'd346,12'd323,12'd220,12'd174,12'd133,12'd324,12'd215,12'd246,
    12'd159,12'd337,12'd254,12'd423,12'd484,12'd239,12'd440,12'd362,12'd464,12'd376,
    12'd398,12'd174,12'd149,12'd418,12'd306,12'd282,12'd434,12'd196,12'd458,12'd313,
    12'd512,12'd450,12'd161,12'd315,12'd441,12'd549,12'd555,12'd431,12'd295,12'd557,
    12'd172,12'd343,12'd472,12'd604,12'd297,12'd524,12'd251,12'd514,12'd385,12'd531,
    12'd663,12'd674,12'd255,12'd519,12'd324,12'd391,12'd394,12'd533,12'd253,12'd717,
    12'd651,12'd399,12'd596,12'd676,12'd425,12'd261,12'd404,12'd691,12'd604,12'd274,
    12'd627,12'd777,12'd269,12'd217,12'd599,12'd447,12'd581,12'd640,12'd666,12'd595,
    12'd669,12'd686,12'd305,12'd460,12'd599,12'd335,12'd258,12'd649,12'd771,12'd619,
    12'd666,12'd669,12'd707,12'd737,12'd854,12'd925,12'd818,12'd424,12'd493,12'd463,
    12'd535,12'd782,12'd476,12'd451,12'd520,12'd886,12'd340,12'd793,12'd390,12'd381,
    12'd274,12'd500,12'd581,12'd345,12'd363,12'd1024,12'd514,12'd773,12'd932,12'd556,
    12'd954,12'd793,12'd294,12'd863,12'd393,12'd827,12'd527,12'd1007,12'd622,12'd549,
    12'd613,12'd799,12'd408,12'd856,12'd601,12'd1072,12'd938,12'd322,12'd1142,12'd873,
    12'd629,12'd1071,12'd1063,12'd1205,12'd596,12'd973,12'd984,12'd875,12'd918,12'd1133,
    12'd1223,12'd933,12'd1110,12'd1228,12'd1017,12'd701,12'd480,12'd678,12'd1172,
    12'd689,12'd1138,12'd1022,12'd682,12'd613,12'd635,12'd984,12'd526,12'd1311,12'd459,
    12'd1348,12'd477,12'd716,12'd1075,12'd682,12'd1245,12'd401,12'd774,12'd1026,12'd499,
    12'd1314,12'd743,12'd693,12'd1282,12'd1003,12'd1181,12'd1079,12'd765,12'd815,
    12'd1350,12'd1144,12'd1449,12'd718,12'd805,12'd1203,12'd1173,12'd737,12'd562,
    12'd579,12'd701,12'd1104,12'd1105,12'd1379,12'd827,12'd1256,12'd759,12'd540,
    12'd1284,12'd1188,12'd776,12'd853,12'd1140,12'd445,12'd1265,12'd802,12'd932,12'd632,
    12'd1504,12'd856,12'd1229,12'd1619,12'd774,12'd1229,12'd1300,12'd1563,12'd1551,
    12'd1265,12'd905,12'd1333,12'd493,12'd913,12'd1397,12'd1250,12'd612,12'd1251,
    12'd1765,12'd1303,12'd595,12'd981,12'd671,12'd1403,12'd820,12'd1404,12'd1661,
    12'd973,12'd1340,12'd1015,12'd1649,12'd855,12'd1834,12'd1621,12'd1704,12'd893,
    12'd1033,12'd721,12'd1737,12'd1507,12'd1851,12'd1006,12'd994,12'd923,12'd872,
    12'd1860
  };

endpackage

// ----- rtl/scrambled_halton_generator_unit.sv -----
// scrambled halton coordinate generator: one coordinate per generate request
// a generate strobes its result when done; every division step uses the one shared
//   divider, which makes one quotient bit per cycle; an in-range load is written on accept
// busy high until the strobe, and no request is accepted while busy; result cannot stall
// reset: control state cleared synchronously; shift digit memory undefined until written
// depends on shg_pkg, shg_divider
module scrambled_halton_generator_unit #(
  parameter int MAX_DIMENSIONS = shg_pkg::MaxDimensions,
  parameter int DIGIT_COUNT    = shg_pkg::DigitCount,
  parameter int FRACTION_BITS  = shg_pkg::FractionBits
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  shg_pkg::in_req_t   in_req,
  output logic               out_strobe,
  output shg_pkg::out_res_t  out_res
);
  import shg_pkg::*;

  localparam int DpW   = $clog2(DIGIT_COUNT);
  localparam int Depth = MAX_DIMENSIONS * DIGIT_COUNT;
  localparam int AddrW = $clog2(Depth);
  localparam int MulW  = 2 * BaseW;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXTR  = 3'd1;
  localparam logic [2:0] ST_EWAIT = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_MOD   = 3'd5;
  localparam logic [2:0] ST_ACC   = 3'd6;
  localparam logic [2:0] ST_AWAIT = 3'd7;

  logic [BaseW-1:0] mem [Depth];
  logic [BaseW-1:0] rd_data_r;

  logic [2:0]             state_r, state_nxt;
  logic [DimW-1:0]        dim_r, dim_nxt;
  logic [IndexW-1:0]      n_r, n_nxt;
  logic [DpW-1:0]         k_r, k_nxt;
  logic [BaseW-1:0]       digits_r [DIGIT_COUNT];
  logic [MulW-1:0]        prod_r, prod_nxt;
  logic [FRACTION_BITS-1:0] frac_r, frac_nxt;
  logic                   strobe_r, strobe_nxt;
  logic                   dig_we;

  logic [DimW-1:0]  in_dim;
  logic [BaseW-1:0] base, factor, ld_val;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic             wr_en;

  logic                   div_start;
  logic                   div_done;
  logic [BaseW-1:0]       d_hi;
  logic [FRACTION_BITS-1:0] d_lo;
  logic [FRACTION_BITS-1:0] d_q;
  logic [BaseW-1:0]       d_rem;

  assign in_dim  = (in_req.dimension >= DimW'(MAX_DIMENSIONS)) ?
                   DimW'(MAX_DIMENSIONS - 1) : in_req.dimension;
  assign base    = BASE_TABLE[(state_r == ST_IDLE) ? in_dim : dim_r];
  assign factor  = FACTOR_TABLE[dim_r];
  assign ld_val  = (in_req.shift_digit >= base) ? base - 1'b1 : in_req.shift_digit;
  assign wr_en   = start && !busy && (in_req.opcode == OP_LOAD) &&
                   ({1'b0, in_req.digit_position} < (PosW+1)'(DIGIT_COUNT));
  assign wr_addr = AddrW'(in_dim * DIGIT_COUNT) + AddrW'(in_req.digit_position[DpW-1:0]);
  assign rd_addr = AddrW'(dim_r * DIGIT_COUNT) + AddrW'(k_r);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= ld_val;
    rd_data_r <= mem[rd_addr];
  end

  // divider operand select: digit extraction divides the 32-bit index, the
  // accumulate step divides e * 2^F + frac, the mod step reduces the product
  always_comb begin
    d_hi = '0;
    d_lo = '0;
    unique case (state_r)
      ST_EXTR: d_lo = FRACTION_BITS'(n_r);
      ST_MOD:  d_lo = FRACTION_BITS'(prod_r);
      ST_ACC:  begin
        d_hi = d_rem;
        d_lo = frac_r;
      end
      default: ;
    endcase
  end

  shg_divider #(.W(FRACTION_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .base(base),
    .hi(d_hi), .lo(d_lo), .done(div_done),
    .quotient(d_q), .remainder(d_rem)
  );

  always_comb begin
    state_nxt  = state_r;
    dim_nxt    = dim_r;
    n_nxt      = n_r;
    k_nxt      = k_r;
    prod_nxt   = prod_r;
    frac_nxt   = frac_r;
    strobe_nxt = 1'b0;
    div_start  = 1'b0;
    dig_we     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start && in_req.opcode == OP_GENERATE) begin
          dim_nxt   = in_dim;
          n_nxt     = in_req.point_index;
          k_nxt     = '0;
          frac_nxt  = '0;
          state_nxt = ST_EXTR;
        end
      end
      ST_EXTR: begin
        div_start = 1'b1;
        state_nxt = ST_EWAIT;
      end
      ST_EWAIT: begin
        if (div_done) begin
          dig_we = 1'b1;
          n_nxt  = d_q[IndexW-1:0];
          if (k_r == DpW'(DIGIT_COUNT - 1)) begin
            state_nxt = ST_RD;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_EXTR;
          end
        end
      end
      ST_RD: state_nxt = ST_MUL;  // memory read latency
      ST_MUL: begin
        prod_nxt   = MulW'(factor) * MulW'(digits_r[k_r]) + MulW'(rd_data_r);
        state_nxt  = ST_MOD;
      end
      ST_MOD: begin
        div_start = 1'b1;
        state_nxt = ST_AWAIT;
        frac_nxt  = frac_r;
      end
      ST_AWAIT: begin
        if (div_done) begin
          // after the mod pass remainder holds e; second pass divides e:frac
          if (prod_r != '1) begin
            prod_nxt  = '1;
            state_nxt = ST_ACC;
          end else begin
            frac_nxt = d_q;
            if (k_r == '0) begin
              strobe_nxt = 1'b1;
              state_nxt  = ST_IDLE;
            end else begin
              k_nxt     = k_r - 1'b1;
              state_nxt = ST_RD;
            end
          end
        end
      end
      ST_ACC: begin
        div_start = 1'b1;
        state_nxt = ST_AWAIT;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    dim_r  <= dim_nxt;
    n_r    <= n_nxt;
    k_r    <= k_nxt;
    prod_r <= prod_nxt;
    frac_r <= frac_nxt;
    if (dig_we) digits_r[k_r] <= d_rem;
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  assign busy                   = (state_r != ST_IDLE);
  assign out_strobe             = strobe_r;
  assign out_res.coordinate     = frac_r[FRACTION_BITS-1 -: CoordW];
  assign out_res.dimension_echo = dim_r;
endmodule

// ----- rtl/shg_divider.sv -----
// shared restoring divider: (hi * 2^W + lo) / base, one quotient bit per cycle
// hi < base; depends on shg_pkg
module shg_divider #(
  parameter int W = 40
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [shg_pkg::BaseW-1:0] base,
  input  logic [shg_pkg::BaseW-1:0] hi,
  input  logic [W-1:0]             lo,
  output logic                     done,
  output logic [W-1:0]             quotient,
  output logic [shg_pkg::BaseW-1:0] remainder
);
  import shg_pkg::*;

  localparam int CntW = $clog2(W + 1);

  logic [BaseW-1:0] rem_r, rem_nxt;
  logic [W-1:0]     shf_r, shf_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [BaseW:0]   trial;

  always_comb begin
    rem_nxt  = rem_r;
    shf_nxt  = shf_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, shf_r[W-1]};
    if (start) begin
      rem_nxt  = hi;
      shf_nxt  = lo;
      cnt_nxt  = CntW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // quotient bits shift in where dividend bits shift out
      if (trial >= {1'b0, base}) begin
        rem_nxt = BaseW'(trial - {1'b0, base});
        shf_nxt = {shf_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[BaseW-1:0];
        shf_nxt = {shf_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    shf_r <= shf_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = shf_r;
  assign remainder = rem_r;
endmodule

// ----- verif/shg_checker.sv -----
// request/result checker for the scrambled halton generator: predicts every coordinate
// from its own copy of the shift digit memory and compares each strobed result
// depends on shg_pkg
module shg_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  shg_pkg::in_req_t  in_req,
  input  logic              out_strobe,
  input  shg_pkg::out_res_t out_res,
  output int                errors,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import shg_pkg::*;

  localparam int FracW = FractionBits;

  logic [BaseW-1:0] shift_mem [MaxDimensions*DigitCount];
  out_res_t coord_queue [$];

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] d);
    return (d >= MaxDimensions) ? DimW'(MaxDimensions - 1) : d;
  endfunction

  function automatic out_res_t halton_coord(input logic [DimW-1:0] dim_raw,
                                            input logic [IndexW-1:0] idx);
    logic [DimW-1:0] dim;
    longint unsigned base, factor, n, e, frac;
    longint unsigned digits [DigitCount];
    out_res_t r;
    dim = clamp_dim(dim_raw);
    base = BASE_TABLE[dim];
    factor = FACTOR_TABLE[dim];
    n = idx;
    frac = 0;
    for (int k = 0; k < DigitCount; k++) begin
      digits[k] = n % base;
      n = n / base;
    end
    // radical inverse from the top digit down, floor division each step
    for (int k = DigitCount - 1; k >= 0; k--) begin
      e = (factor * digits[k] + shift_mem[dim*DigitCount + k]) % base;
      frac = ((e << FracW) + frac) / base;
    end
    r.coordinate = frac[FracW-1 -: CoordW];
    r.dimension_echo = dim;
    return r;
  endfunction

  always @(posedge clk) begin
    out_res_t exp_r;
    logic [DimW-1:0] d;
    logic [BaseW-1:0] v;
    if (!rst_n) begin
      errors <= 0;
      pending <= 0;
      coord_queue.delete();
    end else begin
      if (start && !busy) begin
        d = clamp_dim(in_req.dimension);
        if (in_req.opcode == OP_LOAD) begin
          if (in_req.digit_position < DigitCount) begin
            v = (in_req.shift_digit >= BASE_TABLE[d]) ? BASE_TABLE[d] - 1 : in_req.shift_digit;
            shift_mem[d*DigitCount + in_req.digit_position] = v;
          end
        end else begin
          coord_queue.push_back(halton_coord(in_req.dimension, in_req.point_index));
        end
      end
      if (out_strobe) begin
        if (coord_queue.size() == 0) begin
          $display("%0t: unexpected result coord=%h dim=%0d", $time,
                   out_res.coordinate, out_res.dimension_echo);
          errors <= errors + 1;
        end else begin
          exp_r = coord_queue.pop_front();
          if (exp_r.coordinate !== out_res.coordinate ||
              exp_r.dimension_echo !== out_res.dimension_echo) begin
            $display("%0t: mismatch expected coord=%h dim=%0d actual coord=%h dim=%0d",
                     $time, exp_r.coordinate, exp_r.dimension_echo,
                     out_res.coordinate, out_res.dimension_echo);
            errors <= errors + 1;
          end
        end
      end
      pending <= coord_queue.size();
    end
  end

endmodule

// ----- verif/testbench.sv -----
// top of the scrambled halton generator bench: clock, reset, request stimulus and verdict
// depends on shg_pkg, shg_checker and the generator rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import shg_pkg::*;

  localparam int CycleLimit = 20000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_req_t in_req = '0;
  logic out_strobe;
  out_res_t out_res;
  int errors, pending;
  int cycles = 0;
  int n_items = 0, n_gen = 0, n_load = 0;
  bit dim_ready [MaxDimensions];
  int ready_list [$];

  always #6 clk = ~clk;

  scrambled_halton_generator_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_strobe(out_strobe), .out_res(out_res)
  );

  shg_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_strobe(out_strobe), .out_res(out_res), .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // busy is registered, so a low value seen at the falling edge holds to the next rising edge
  task automatic send(input in_req_t r);
    @(negedge clk);
    start <= 1'b1;
    in_req <= r;
    while (busy) @(negedge clk);
    @(posedge clk);
    n_items++;
    if (r.opcode == OP_LOAD) n_load++;
    else n_gen++;
  endtask

  task automatic idle(input int n);
    @(negedge clk);
    start <= 1'b0;
    in_req <= in_req_t'({$urandom, $urandom});
    repeat (n) @(posedge clk);
  endtask

  task automatic load_digit(input int dim, input int pos, input int val);
    in_req_t r;
    r = in_req_t'({$urandom, $urandom});
    r.opcode = OP_LOAD;
    r.dimension = DimW'(dim);
    r.digit_position = PosW'(pos);
    r.shift_digit = BaseW'(val);
    send(r);
  endtask

  task automatic generate_coord(input int dim, input logic [31:0] idx);
    in_req_t r;
    int d;
    d = (dim >= MaxDimensions) ? MaxDimensions - 1 : dim;
    // every digit of a dimension must be written before it is read
    if (!dim_ready[d]) begin
      for (int p = 0; p < DigitCount; p++)
        load_digit(dim, p, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                       : $urandom_range(0, BASE_TABLE[d]-1));
      dim_ready[d] = 1'b1;
      ready_list.push_back(d);
    end
    r = in_req_t'({$urandom, $urandom});
    r.opcode = OP_GENERATE;
    r.dimension = DimW'(dim);
    r.point_index = idx;
    send(r);
  endtask

  function automatic logic [31:0] rand_index();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 64);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 64);
      2: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int dim;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: smallest and largest base, index extremes, clamped dimensions
    for (int p = 0; p < DigitCount; p++) load_digit(0, p, 4095);
    dim_ready[0] = 1'b1;
    ready_list.push_back(0);
    generate_coord(0, 32'h0);
    generate_coord(0, 32'hFFFF_FFFF);
    generate_coord(0, 32'h1);
    for (int p = 0; p < DigitCount; p++) load_digit(359, p, (p % 2) ? 0 : 2422);
    dim_ready[359] = 1'b1;
    ready_list.push_back(359);
    generate_coord(359, 32'h0);
    generate_coord(359, 32'hFFFF_FFFF);
    generate_coord(511, 32'h1234_5678);
    generate_coord(360, 32'h8000_0000);
    load_digit(511, 31, 4095);
    generate_coord(359, 32'h7FFF_FFFF);

    while (n_items < 600) begin
      if ($urandom_range(0, 1)) begin
        dim = (ready_list.size() > 0 && $urandom_range(0, 2) != 0)
              ? ready_list[$urandom_range(0, ready_list.size()-1)] : $urandom_range(0, 511);
        generate_coord(dim, rand_index());
      end else begin
        load_digit($urandom_range(0, 511), $urandom_range(0, 31), $urandom_range(0, 4095));
      end
      // bursts with random gaps between them
      if ($urandom_range(0, 3) == 0) idle($urandom_range(1, 40));
      if (n_items > 300 && n_items < 305) begin
        idle(1);
        wait (pending == 0);
      end
    end
    idle(1);
    wait (pending == 0);
    repeat (30) @(posedge clk);

    $display("covered %0d requests: %0d coordinates and %0d shift digit loads", n_items,
             n_gen, n_load);
    $display("dimensions prepared: %0d, clamped and saturating values included",
             ready_list.size());
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
